// ----- rtl/sorted_wakeup_deadline_queue_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the sorted wakeup deadline queue unit
// Shared concurrent assertion forms with a common clock and reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_WAKEUP_DEADLINE_QUEUE_UNIT_DEFINES_SVH
`define SORTED_WAKEUP_DEADLINE_QUEUE_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SWDQ_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("swdq assertion failed");

// Next-cycle implication, checked outside reset.
`define SWDQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("swdq assertion failed");

`endif

// ----- rtl/swdq_pkg.sv -----
// ----------------------------------------------------------------------------
// swdq_pkg
// Types and constants shared by the sorted wakeup deadline queue modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package swdq_pkg;

  // Queue size and the most wakeups reported for one tick.
  localparam int QUEUE_DEPTH  = 16;
  localparam int RESULT_LIMIT = 16;

  // Derived widths: pointer, fill count and per-tick pop count.
  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int NUM_W = $clog2(RESULT_LIMIT + 1);

  // Operation codes of an input item.
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_SLEEP = 1'b1;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_ACCEPTED = 2'd0,
    KIND_FULL     = 2'd1,
    KIND_WOKEN    = 2'd2
  } kind_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INSERT,
    ST_POP
  } state_t;

  // One input item.
  typedef struct packed {
    logic               operation;
    logic [7:0]         thread_id;
    logic signed [31:0] sleep_ticks;
  } in_item_t;

  // One result item.
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  woken_id;
    logic [62:0] now_ticks;
    logic        last;
  } result_t;

  // One queue entry as held in the memory.
  typedef struct packed {
    logic [63:0] wake_time;
    logic [7:0]  sleeper_id;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Result handed from the controller to the output register.
  typedef struct packed {
    logic    valid;
    result_t res;
  } emit_t;

endpackage

`default_nettype wire

// ----- rtl/swdq_ram.sv -----
// ----------------------------------------------------------------------------
// swdq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swdq_ram #(
  parameter int WIDTH  = 72,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port with registered data.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/swdq_ctrl.sv -----
// ----------------------------------------------------------------------------
// swdq_ctrl
// Sequencer for the sorted queue: ring pointers, tick counter, insert and pop.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_wakeup_deadline_queue_unit_defines.svh"

module swdq_ctrl
  import swdq_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire in_item_t             item,
  output logic                      busy,
  output emit_t                     emit,
  output logic                      mem_we,
  output logic      [PTR_W-1:0]     mem_waddr,
  output logic      [ENTRY_W-1:0]   mem_wdata,
  output logic      [PTR_W-1:0]     mem_raddr,
  input  wire logic [ENTRY_W-1:0]   mem_rdata
);

  state_t            state;
  state_t            state_next;
  logic [63:0]       tick_count;
  logic [PTR_W-1:0]  head;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  gap;
  logic [NUM_W-1:0]  pop_n;
  logic [63:0]       wake_reg;
  logic [7:0]        id_reg;
  logic              pend_valid;
  logic [7:0]        pend_id;

  entry_t rd;
  logic   accept;
  logic   full;
  logic   later;
  logic   place;
  logic   due;

  // Physical slot of a logical offset from the head, wrapping at the depth.
  function automatic logic [PTR_W-1:0] wrap(input logic [PTR_W-1:0] ptr,
                                            input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(ptr) + (CNT_W + 1)'(off);
    if (sum >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
      sum = sum - (CNT_W + 1)'(QUEUE_DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  // Decisions taken on the entry that the memory returns this cycle.
  assign rd     = entry_t'(mem_rdata);
  assign accept = start && (state == ST_IDLE);
  assign full   = (count == CNT_W'(QUEUE_DEPTH));
  assign later  = $signed(wake_reg) < $signed(rd.wake_time);
  assign place  = (gap == '0) || !later;
  assign due    = (count != '0) && (pop_n < NUM_W'(RESULT_LIMIT)) &&
                  !($signed(tick_count) < $signed(rd.wake_time));
  assign busy   = (state != ST_IDLE);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (item.operation == OP_TICK) begin
            state_next = ST_POP;
          end else if (!full) begin
            state_next = ST_INSERT;
          end
        end
      end
      ST_INSERT: begin
        if (place) begin
          state_next = ST_IDLE;
        end
      end
      ST_POP: begin
        if (!due) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Memory accesses and results.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wrap(head, gap);
    mem_wdata = '0;
    mem_raddr = head;
    emit      = '0;
    unique case (state)
      ST_IDLE: begin
        // Start at the tail for a sleep, at the head for a tick.
        if (accept && item.operation == OP_SLEEP && count != '0) begin
          mem_raddr = wrap(head, count - CNT_W'(1));
        end
        if (accept && item.operation == OP_SLEEP && full) begin
          emit.valid        = 1'b1;
          emit.res.kind     = KIND_FULL;
          emit.res.woken_id = item.thread_id;
          emit.res.now_ticks = tick_count[62:0];
          emit.res.last     = 1'b1;
        end
      end
      ST_INSERT: begin
        // Either move the later entry up one slot or drop the new one in.
        mem_we = 1'b1;
        if (place) begin
          mem_wdata          = {wake_reg, id_reg};
          emit.valid         = 1'b1;
          emit.res.kind      = KIND_ACCEPTED;
          emit.res.woken_id  = id_reg;
          emit.res.now_ticks = tick_count[62:0];
          emit.res.last      = 1'b1;
        end else begin
          mem_wdata = mem_rdata;
          if (gap >= CNT_W'(2)) begin
            mem_raddr = wrap(head, gap - CNT_W'(2));
          end
        end
      end
      ST_POP: begin
        // A woken entry is held in the pending register so its last flag is known.
        if (due) begin
          mem_raddr = wrap(head, CNT_W'(1));
        end
        if (pend_valid) begin
          emit.valid         = 1'b1;
          emit.res.kind      = KIND_WOKEN;
          emit.res.woken_id  = pend_id;
          emit.res.now_ticks = tick_count[62:0];
          emit.res.last      = !due;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      tick_count <= '0;
      head       <= '0;
      count      <= '0;
      pend_valid <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          pend_valid <= 1'b0;
          if (accept && item.operation == OP_TICK) begin
            tick_count <= tick_count + 64'd1;
          end
        end
        ST_INSERT: begin
          if (place) begin
            count <= count + CNT_W'(1);
          end
        end
        ST_POP: begin
          if (due) begin
            head       <= wrap(head, CNT_W'(1));
            count      <= count - CNT_W'(1);
            pend_valid <= 1'b1;
          end else begin
            pend_valid <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        pop_n    <= '0;
        gap      <= count;
        id_reg   <= item.thread_id;
        wake_reg <= tick_count + {{32{item.sleep_ticks[31]}}, item.sleep_ticks};
      end
      ST_INSERT: begin
        if (!place) begin
          gap <= gap - CNT_W'(1);
        end
      end
      ST_POP: begin
        if (due) begin
          pop_n   <= pop_n + NUM_W'(1);
          pend_id <= rd.sleeper_id;
        end
      end
      default: begin
      end
    endcase
  end

  // Checks on the sequencer.
  `SWDQ_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(QUEUE_DEPTH))
  `SWDQ_ASSERT_NOW(a_insert_kind, clk, rst, emit.valid && state == ST_INSERT, emit.res.kind == KIND_ACCEPTED && emit.res.last)
  `SWDQ_ASSERT_NOW(a_pop_kind, clk, rst, emit.valid && state == ST_POP, emit.res.kind == KIND_WOKEN)
  `SWDQ_ASSERT_NEXT(a_full_stays, clk, rst, accept && item.operation == OP_SLEEP && full, state == ST_IDLE && $stable(count))
  `SWDQ_ASSERT_NOW(a_gap_bound, clk, rst, state == ST_INSERT, gap < CNT_W'(QUEUE_DEPTH) && gap == count - (count - gap))

endmodule

`default_nettype wire

// ----- rtl/sorted_wakeup_deadline_queue_unit.sv -----
// ----------------------------------------------------------------------------
// sorted_wakeup_deadline_queue_unit
// Tick counter with a wake-time sorted queue of sleeping thread ids.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. A sleep item keeps
// busy high while the k queued entries that wake later than the new one move
// up and the new entry is written; each of those moves up one slot through
// the queue memory's single read and write port, one entry per cycle. A sleep
// item on a full queue is answered at once and leaves busy low. A tick item
// keeps busy high while it wakes its n threads, one memory read per cycle.
// Results come out on result, marked by strobe for one cycle, at most one per
// cycle; the receiver cannot hold them off, so it must take each one in the
// cycle it appears. The last result of each item has last set.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sorted_wakeup_deadline_queue_unit
  import swdq_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  output logic          busy,
  input  wire in_item_t item,
  output logic          strobe,
  output result_t       result
);

  emit_t              emit;
  logic               mem_we;
  logic [PTR_W-1:0]   mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic [PTR_W-1:0]   mem_raddr;
  logic [ENTRY_W-1:0] mem_rdata;

  // Queue entries: wake time and thread id, kept as a ring.
  swdq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH),
    .ADDR_W(PTR_W)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // Sequencer.
  swdq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .item     (item),
    .busy     (busy),
    .emit     (emit),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  // Output register: strobe is control, the result payload needs no reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= emit.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      result <= emit.res;
    end
  end

endmodule

`default_nettype wire

// ----- test/sorted_wakeup_deadline_queue_unit_tb.sv -----
// ----------------------------------------------------------------------------
// sorted_wakeup_deadline_queue_unit_tb
// Self-checking bench for the sorted wakeup deadline queue. A short directed
// table covers reset values, extreme sleep counts, equal wake times, a full
// queue and a tick that wakes many threads. Random sleep and tick items
// follow. Every result is compared with a built-in model of the tick counter
// and the sorted sleeper queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_wakeup_deadline_queue_unit_tb;
  import swdq_pkg::*;

  localparam int RANDOM_ITEMS = 155;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 40;
  localparam int SHOW_LIMIT   = 10;

  // One row of the directed table.
  typedef struct {
    in_item_t it;
    bit       typed;
    result_t  want;
  } dir_row_t;

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  in_item_t item;
  logic     strobe;
  result_t  result;

  // Typed expectation that travels with the item being offered.
  logic     row_typed;
  result_t  row_want;

  // Model state: tick counter and sorted sleeper queue.
  logic signed [63:0] now_ticks_m;
  logic signed [63:0] wake_m [QUEUE_DEPTH];
  logic [7:0]         sleeper_m [QUEUE_DEPTH];
  int                 fill_m;

  result_t  wakeup_q [$];
  dir_row_t rows [$];
  int       mismatches;
  int       cycles;
  bit       no_idle;

  sorted_wakeup_deadline_queue_unit u_top (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .strobe (strobe),
    .result (result)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("sorted_wakeup_deadline_queue_unit regression: fail");
      $finish;
    end
  end

  function automatic result_t mk_result(kind_t k, logic [7:0] id, logic [62:0] now,
                                        logic lst);
    result_t r;
    r.kind      = k;
    r.woken_id  = id;
    r.now_ticks = now;
    r.last      = lst;
    return r;
  endfunction

  // Advance the model by one item and queue the results it causes.
  task automatic model_item(input in_item_t it);
    logic signed [63:0] delta;
    logic signed [63:0] wake;
    int pos;
    int n;
    if (it.operation == OP_SLEEP) begin
      if (fill_m >= QUEUE_DEPTH) begin
        wakeup_q.push_back(mk_result(KIND_FULL, it.thread_id, now_ticks_m[62:0], 1'b1));
      end else begin
        delta = it.sleep_ticks;
        wake  = now_ticks_m + delta;
        // Insert behind every entry with an equal wake time.
        pos = 0;
        while (pos < fill_m && !(wake < wake_m[pos])) pos++;
        for (int i = fill_m; i > pos; i--) begin
          wake_m[i]    = wake_m[i - 1];
          sleeper_m[i] = sleeper_m[i - 1];
        end
        wake_m[pos]    = wake;
        sleeper_m[pos] = it.thread_id;
        fill_m++;
        wakeup_q.push_back(mk_result(KIND_ACCEPTED, it.thread_id, now_ticks_m[62:0],
                                     1'b1));
      end
    end else begin
      now_ticks_m = now_ticks_m + 64'sd1;
      n = 0;
      // Pop every due entry from the front, up to the per-tick limit.
      while (n < RESULT_LIMIT && fill_m > 0 && !(now_ticks_m < wake_m[0])) begin
        wakeup_q.push_back(mk_result(KIND_WOKEN, sleeper_m[0], now_ticks_m[62:0], 1'b0));
        n++;
        for (int i = 1; i < fill_m; i++) begin
          wake_m[i - 1]    = wake_m[i];
          sleeper_m[i - 1] = sleeper_m[i];
        end
        fill_m--;
      end
      if (n > 0) wakeup_q[wakeup_q.size() - 1].last = 1'b1;
    end
  endtask

  // Result checking first, then prediction for an item taken at this edge.
  always @(posedge clk) begin : monitor
    result_t want;
    int      first;
    if (rst) begin
      wakeup_q.delete();
      now_ticks_m = '0;
      fill_m      = 0;
    end else begin
      if (strobe) begin
        if (wakeup_q.size() == 0) begin
          mismatches++;
          if (mismatches <= SHOW_LIMIT)
            $display("unexpected result: kind %0d id %0d now %0d last %0d",
                     result.kind, result.woken_id, result.now_ticks, result.last);
        end else begin
          want = wakeup_q.pop_front();
          if (result !== want) begin
            mismatches++;
            if (mismatches <= SHOW_LIMIT)
              $display("mismatch: expected kind %0d id %0d now %0d last %0d, %s",
                       want.kind, want.woken_id, want.now_ticks, want.last,
                       $sformatf("actual kind %0d id %0d now %0d last %0d",
                                 result.kind, result.woken_id, result.now_ticks,
                                 result.last));
          end
        end
      end
      if (start && !busy) begin
        first = wakeup_q.size();
        model_item(item);
        if (row_typed && wakeup_q.size() > first) wakeup_q[first] = row_want;
      end
    end
  end

  // Offer one item after a random gap and wait until the block takes it.
  task automatic send_item(input in_item_t it, input bit typed, input result_t want);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    item      <= it;
    row_typed <= typed;
    row_want  <= want;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic void add_row(logic op, logic [7:0] id, logic signed [31:0] ticks,
                                  bit typed, kind_t k, logic [62:0] now);
    dir_row_t r;
    r.it.operation   = op;
    r.it.thread_id   = id;
    r.it.sleep_ticks = ticks;
    r.typed          = typed;
    r.want           = mk_result(k, id, now, 1'b1);
    rows.push_back(r);
  endfunction

  // Random item: sleep share is biased per stretch so the queue both fills
  // up and drains.
  function automatic in_item_t rand_item(int sleep_pct);
    in_item_t it;
    it.operation = ($urandom_range(0, 99) < sleep_pct) ? OP_SLEEP : OP_TICK;
    it.thread_id = $urandom_range(0, 255);
    case ($urandom_range(0, 19))
      0, 1:    it.sleep_ticks = -$signed(32'($urandom_range(1, 4)));
      2:       it.sleep_ticks = 32'h8000_0000 | 32'($urandom);
      3:       it.sleep_ticks = $urandom;
      4:       it.sleep_ticks = ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: it.sleep_ticks = $urandom_range(0, 6);
    endcase
    return it;
  endfunction

  // Stimulus.
  initial begin
    int       sleep_pct;
    in_item_t it;
    rst        = 1'b1;
    start      = 1'b0;
    item       = '0;
    row_typed  = 1'b0;
    row_want   = '0;
    mismatches = 0;
    cycles     = 0;
    no_idle    = 1'b0;

    // Directed table: reset values, extreme counts, equal wake times,
    // a full queue and a tick that wakes a crowd.
    add_row(OP_SLEEP, 8'h00, 32'sd0, 1'b1, KIND_ACCEPTED, 63'd0);
    add_row(OP_TICK, 8'h00, 32'sd0, 1'b1, KIND_WOKEN, 63'd1);
    add_row(OP_TICK, 8'hFF, -32'sd1, 1'b0, KIND_WOKEN, 63'd0);
    add_row(OP_SLEEP, 8'hFF, 32'sh7FFF_FFFF, 1'b1, KIND_ACCEPTED, 63'd2);
    add_row(OP_SLEEP, 8'hAA, 32'sh8000_0000, 1'b1, KIND_ACCEPTED, 63'd2);
    add_row(OP_SLEEP, 8'h55, -32'sd1, 1'b1, KIND_ACCEPTED, 63'd2);
    add_row(OP_SLEEP, 8'h11, 32'sd3, 1'b0, KIND_ACCEPTED, 63'd0);
    add_row(OP_SLEEP, 8'h12, 32'sd3, 1'b0, KIND_ACCEPTED, 63'd0);
    add_row(OP_SLEEP, 8'h13, 32'sd1, 1'b0, KIND_ACCEPTED, 63'd0);
    add_row(OP_TICK, 8'h00, 32'sd0, 1'b0, KIND_WOKEN, 63'd0);
    for (int i = 0; i < QUEUE_DEPTH - 3; i++)
      add_row(OP_SLEEP, 8'(8'h20 + i), 32'((i % 4) - 1), 1'b1, KIND_ACCEPTED, 63'd3);
    add_row(OP_SLEEP, 8'hEE, 32'sd5, 1'b1, KIND_FULL, 63'd3);
    add_row(OP_TICK, 8'h00, 32'sd0, 1'b0, KIND_WOKEN, 63'd0);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) send_item(rows[i].it, rows[i].typed, rows[i].want);

    // Random part.
    sleep_pct = 50;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 30 == 0) sleep_pct = $urandom_range(25, 80);
      no_idle = (n >= 120 && n < 150);
      // Let everything drain once before going on.
      if (n == 90) begin
        start <= 1'b0;
        @(posedge clk);
        while (wakeup_q.size() != 0) @(posedge clk);
      end
      it = rand_item(sleep_pct);
      send_item(it, 1'b0, '0);
    end
    start <= 1'b0;

    // Wait for the remaining results, then a few more cycles.
    while (wakeup_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && wakeup_q.size() == 0) begin
      $display("sorted_wakeup_deadline_queue_unit regression: pass");
    end else begin
      $display("sorted_wakeup_deadline_queue_unit regression: fail");
    end
    $finish;
  end

endmodule
